// File: sv/lpg_pkg.sv
// Shared types and constants of the LED pixel glow/fade filter.
// No dependencies; every other file of the block refers to this package.
package lpg_pkg;

  localparam int COLOR_W    = 8;
  localparam int IDX_W      = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int STEP_W     = 4;

  // Division by 100 is done as a multiplication by 5243 / 2^19, which is exact
  // for every dividend below 43699. Glow dividends stay below 25501.
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 19;
  localparam int COEF_W      = 20;
  localparam int TERM_W      = COLOR_W + 1;
  localparam logic [RECIP_W-1:0] RECIP = 13'd5243;

  localparam logic [CFG_DATA_W-1:0] PCT_FULL   = 7'd100;
  localparam logic [CFG_DATA_W-1:0] GLOW_MAX   = 7'd99;
  localparam logic [CFG_DATA_W-1:0] FADE_MAX   = 7'd10;
  localparam logic [CFG_DATA_W-1:0] RST_AMOUNT = 7'd1;

  localparam logic [COEF_W-1:0] RST_IN_COEF =
    COEF_W'((int'(PCT_FULL) - int'(RST_AMOUNT)) * int'(RECIP));
  localparam logic [COEF_W-1:0] RST_OLD_COEF =
    COEF_W'(int'(RST_AMOUNT) * int'(RECIP));
  localparam logic [STEP_W-1:0] RST_STEP = STEP_W'(RST_AMOUNT);

  typedef enum logic [1:0] {
    MODE_PASS = 2'd0,
    MODE_GLOW = 2'd1,
    MODE_FADE = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 1'b0,
    CFG_AMOUNT = 1'b1
  } cfg_idx_t;

  // Effect settings, with the amount already clamped and turned into
  // glow weights scaled by the reciprocal of 100, and into the fade step.
  typedef struct packed {
    logic [1:0]        mode;
    logic [COEF_W-1:0] in_coef;
    logic [COEF_W-1:0] old_coef;
    logic [STEP_W-1:0] fade_step;
  } cfg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

endpackage

// File: sv/lpg_pix_if.sv
// Valid/ready pixel channels of the LED pixel glow/fade filter.
// Depends on lpg_pkg for the field widths.
interface lpg_in_if;
  logic                        valid;
  logic                        ready;
  logic [lpg_pkg::IDX_W-1:0]   led_index;
  logic [lpg_pkg::COLOR_W-1:0] in_red;
  logic [lpg_pkg::COLOR_W-1:0] in_green;
  logic [lpg_pkg::COLOR_W-1:0] in_blue;
  logic                        frame_last;

  modport source (output valid, led_index, in_red, in_green, in_blue, frame_last,
                  input ready);
  modport sink (input valid, led_index, in_red, in_green, in_blue, frame_last,
                output ready);
endinterface

interface lpg_out_if;
  logic                        valid;
  logic                        ready;
  logic [lpg_pkg::IDX_W-1:0]   out_index;
  logic [lpg_pkg::COLOR_W-1:0] out_red;
  logic [lpg_pkg::COLOR_W-1:0] out_green;
  logic [lpg_pkg::COLOR_W-1:0] out_blue;
  logic                        out_last;

  modport source (output valid, out_index, out_red, out_green, out_blue, out_last,
                  input ready);
  modport sink (input valid, out_index, out_red, out_green, out_blue, out_last,
                output ready);
endinterface

// File: sv/led_pixel_glow_fade_filter.sv
// Top level of the LED pixel glow/fade filter: input register, per-LED color
// history, three channel datapaths and the result register.
// Depends on lpg_pkg, lpg_pix_if, lpg_cfg and lpg_chan.
//
//   Port      Dir  Handshake      Word
//   in_pix    in   valid/ready    led_index, in_red/green/blue, frame_last
//   out_pix   out  valid/ready    out_index, out_red/green/blue, out_last
//   cfg_*     in   write enable   cfg_idx selects mode or amount, cfg_wdata
//
// One word per cycle when out_pix does not stall; input and result are registered.
// The history is read and written in the same stage, so a pixel always sees the
// color left by the previous glow or fade pixel of its LED with no extra latency.
// Reset clears the history of every LED to black in the same cycle.
// When out_pix.ready is low the result holds and the input register still fills
// once; after that in_pix.ready drops until the result is taken.
module led_pixel_glow_fade_filter #(
  parameter int LED_COUNT = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lpg_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [lpg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  lpg_in_if.sink                         in_pix,
  lpg_out_if.source                      out_pix
);

  // Only the first eight LEDs can be addressed by a three-bit index.
  localparam int IDX_SPAN   = 1 << lpg_pkg::IDX_W;
  localparam int HIST_DEPTH = (LED_COUNT < IDX_SPAN) ? LED_COUNT : IDX_SPAN;
  localparam int SLOT_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

  lpg_pkg::cfg_t                 cfg;

  logic                          in_vld_r;
  logic [lpg_pkg::IDX_W-1:0]     idx_r;
  lpg_pkg::rgb_t                 pix_r;
  logic                          last_r;

  logic                          out_vld_r;
  logic [lpg_pkg::IDX_W-1:0]     out_idx_r;
  lpg_pkg::rgb_t                 out_pix_r;
  logic                          out_last_r;

  lpg_pkg::rgb_t                 hist_r [HIST_DEPTH];

  logic [SLOT_W-1:0]             slot_lut [IDX_SPAN];
  logic [SLOT_W-1:0]             slot;
  lpg_pkg::rgb_t                 old_rgb;
  lpg_pkg::rgb_t                 res_rgb;
  logic                          out_free;
  logic                          advance;
  logic                          in_ready;
  logic                          hist_we;

  // LED index to history slot, reduced modulo the strip length.
  for (genvar k = 0; k < IDX_SPAN; k++) begin : g_slot
    assign slot_lut[k] = SLOT_W'(k % LED_COUNT);
  end

  lpg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign slot     = slot_lut[idx_r];
  assign old_rgb  = hist_r[slot];
  assign out_free = !out_vld_r || out_pix.ready;
  assign advance  = in_vld_r && out_free;
  assign in_ready = !in_vld_r || advance;
  assign hist_we  = advance && (cfg.mode == lpg_pkg::MODE_GLOW ||
                                cfg.mode == lpg_pkg::MODE_FADE);

  lpg_chan u_chan_red (
    .cfg     (cfg),
    .new_val (pix_r.red),
    .old_val (old_rgb.red),
    .res     (res_rgb.red)
  );

  lpg_chan u_chan_green (
    .cfg     (cfg),
    .new_val (pix_r.green),
    .old_val (old_rgb.green),
    .res     (res_rgb.green)
  );

  lpg_chan u_chan_blue (
    .cfg     (cfg),
    .new_val (pix_r.blue),
    .old_val (old_rgb.blue),
    .res     (res_rgb.blue)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_pix.valid) begin
      idx_r  <= in_pix.led_index;
      pix_r  <= '{red: in_pix.in_red, green: in_pix.in_green, blue: in_pix.in_blue};
      last_r <= in_pix.frame_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_idx_r  <= idx_r;
      out_pix_r  <= res_rgb;
      out_last_r <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
    end else if (hist_we) begin
      hist_r[slot] <= res_rgb;
    end
  end

  assign in_pix.ready      = in_ready;
  assign out_pix.valid     = out_vld_r;
  assign out_pix.out_index = out_idx_r;
  assign out_pix.out_red   = out_pix_r.red;
  assign out_pix.out_green = out_pix_r.green;
  assign out_pix.out_blue  = out_pix_r.blue;
  assign out_pix.out_last  = out_last_r;

  // A new word may replace a held one only while the held one moves on.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (in_pix.valid && in_pix.ready && in_vld_r) |-> advance)
    else $error("input register overwritten while its word was stalled");

  // Passthrough delivers the input pixel unchanged.
  a_pass_exact: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && cfg.mode != lpg_pkg::MODE_GLOW && cfg.mode != lpg_pkg::MODE_FADE)
    |=> (out_pix_r == $past(pix_r)))
    else $error("passthrough result differs from the input pixel");

  // A rising fade lands between the stored color and the target.
  a_fade_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && cfg.mode == lpg_pkg::MODE_FADE && old_rgb.red <= pix_r.red)
    |=> (out_pix_r.red >= $past(old_rgb.red) && out_pix_r.red <= $past(pix_r.red)))
    else $error("fade result left the range between stored and target red");

  // A result appears only after a word was held in the input register.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(in_vld_r))
    else $error("result became valid without a word in the input register");

endmodule

// File: sv/lpg_cfg.sv
// Effect configuration registers: mode, and the amount turned into glow weights
// and a fade step at write time. Depends on lpg_pkg.
module lpg_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lpg_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [lpg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output lpg_pkg::cfg_t                  cfg
);

  logic [1:0]                        mode_r;
  logic [lpg_pkg::COEF_W-1:0]        in_coef_r;
  logic [lpg_pkg::COEF_W-1:0]        old_coef_r;
  logic [lpg_pkg::STEP_W-1:0]        fade_step_r;

  logic [lpg_pkg::CFG_DATA_W-1:0]    glow_amt;
  logic [lpg_pkg::CFG_DATA_W-1:0]    fade_amt;
  logic [lpg_pkg::COEF_W-1:0]        in_coef_nxt;
  logic [lpg_pkg::COEF_W-1:0]        old_coef_nxt;

  always_comb begin
    glow_amt = (cfg_wdata > lpg_pkg::GLOW_MAX) ? lpg_pkg::GLOW_MAX : cfg_wdata;
    fade_amt = (cfg_wdata > lpg_pkg::FADE_MAX) ? lpg_pkg::FADE_MAX : cfg_wdata;
    old_coef_nxt = lpg_pkg::COEF_W'(glow_amt) * lpg_pkg::COEF_W'(lpg_pkg::RECIP);
    in_coef_nxt  = lpg_pkg::COEF_W'(lpg_pkg::PCT_FULL - glow_amt)
                 * lpg_pkg::COEF_W'(lpg_pkg::RECIP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= lpg_pkg::MODE_PASS;
      in_coef_r   <= lpg_pkg::RST_IN_COEF;
      old_coef_r  <= lpg_pkg::RST_OLD_COEF;
      fade_step_r <= lpg_pkg::RST_STEP;
    end else if (cfg_we) begin
      case (cfg_idx)
        lpg_pkg::CFG_MODE: begin
          mode_r <= cfg_wdata[1:0];
        end
        lpg_pkg::CFG_AMOUNT: begin
          in_coef_r   <= in_coef_nxt;
          old_coef_r  <= old_coef_nxt;
          fade_step_r <= fade_amt[lpg_pkg::STEP_W-1:0];
        end
        default: begin
          mode_r <= mode_r;
        end
      endcase
    end
  end

  assign cfg = '{mode: mode_r, in_coef: in_coef_r, old_coef: old_coef_r,
                 fade_step: fade_step_r};

endmodule

// File: sv/lpg_chan.sv
// Per-channel effect datapath: glow smoothing, fade step limiting or pass.
// Depends on lpg_pkg; instantiated once per color by the top level.
module lpg_chan (
  input  lpg_pkg::cfg_t                cfg,
  input  logic [lpg_pkg::COLOR_W-1:0]  new_val,
  input  logic [lpg_pkg::COLOR_W-1:0]  old_val,
  output logic [lpg_pkg::COLOR_W-1:0]  res
);

  localparam int PROD_W = lpg_pkg::COLOR_W + lpg_pkg::COEF_W;

  logic [PROD_W-1:0]              in_prod;
  logic [PROD_W-1:0]              old_prod;
  logic [lpg_pkg::TERM_W-1:0]     in_term;
  logic [lpg_pkg::TERM_W-1:0]     old_term;
  logic [lpg_pkg::TERM_W:0]       glow_sum;
  logic [lpg_pkg::COLOR_W-1:0]    glow_val;
  logic                           rising;
  logic [lpg_pkg::COLOR_W-1:0]    diff;
  logic [lpg_pkg::COLOR_W-1:0]    step;
  logic [lpg_pkg::COLOR_W-1:0]    move;
  logic [lpg_pkg::COLOR_W-1:0]    fade_val;

  always_comb begin
    // Each weighted term is truncated on its own before the sum.
    in_prod  = PROD_W'(new_val) * PROD_W'(cfg.in_coef);
    old_prod = PROD_W'(old_val) * PROD_W'(cfg.old_coef);
    in_term  = in_prod[lpg_pkg::RECIP_SHIFT +: lpg_pkg::TERM_W];
    old_term = old_prod[lpg_pkg::RECIP_SHIFT +: lpg_pkg::TERM_W];
    glow_sum = (lpg_pkg::TERM_W+1)'(in_term) + (lpg_pkg::TERM_W+1)'(old_term);
    glow_val = (glow_sum > (lpg_pkg::TERM_W+1)'(255)) ? '1
                                                      : glow_sum[lpg_pkg::COLOR_W-1:0];

    rising   = new_val > old_val;
    diff     = rising ? (new_val - old_val) : (old_val - new_val);
    step     = lpg_pkg::COLOR_W'(cfg.fade_step);
    move     = (diff < step) ? diff : step;
    fade_val = rising ? (old_val + move) : (old_val - move);

    case (cfg.mode)
      lpg_pkg::MODE_GLOW: res = glow_val;
      lpg_pkg::MODE_FADE: res = fade_val;
      default:            res = new_val;
    endcase
  end

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the LED pixel glow/fade filter: it streams pixel words
// under random stalls, predicts each shown color and checks every result word.
// Depends on lpg_pkg, lpg_pix_if and the led_pixel_glow_fade_filter RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEDS = 8;

  typedef logic [lpg_pkg::COLOR_W-1:0]    color_t;
  typedef logic [lpg_pkg::CFG_DATA_W-1:0] amount_t;

  typedef struct packed {
    logic [lpg_pkg::IDX_W-1:0] idx;
    lpg_pkg::rgb_t             color;
    logic                      last;
  } pixel_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [lpg_pkg::CFG_IDX_W-1:0]  cfg_idx = lpg_pkg::CFG_MODE;
  amount_t                        cfg_wdata = '0;

  lpg_in_if  in_if ();
  lpg_out_if out_if ();

  led_pixel_glow_fade_filter #(.LED_COUNT(LEDS)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_pix    (in_if),
    .out_pix   (out_if)
  );

  // Predicted block state: shown color per LED and the effect settings.
  lpg_pkg::rgb_t         shown_hist [LEDS];
  logic [1:0]            cur_mode = lpg_pkg::MODE_PASS;
  amount_t               cur_amount = lpg_pkg::RST_AMOUNT;

  pixel_t due_pixels [$];
  int     fail_count = 0;
  bit     steady = 1'b0;
  int     stall_left = 0;

  always #4 clk = ~clk;

  initial begin
    in_if.valid      = 1'b0;
    in_if.led_index  = '0;
    in_if.in_red     = '0;
    in_if.in_green   = '0;
    in_if.in_blue    = '0;
    in_if.frame_last = 1'b0;
    out_if.ready     = 1'b0;
    foreach (shown_hist[i]) shown_hist[i] = '0;
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int pick_len();
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int pick_gap();
    if (steady || $urandom_range(0, 99) < 65) return 0;
    return pick_len();
  endfunction

  always @(negedge clk) begin
    if (steady) begin
      out_if.ready = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready = 1'b0;
    end else if ($urandom_range(0, 99) < 20) begin
      stall_left = pick_len() - 1;
      out_if.ready = 1'b0;
    end else begin
      out_if.ready = 1'b1;
    end
  end

  function automatic color_t glow_mix(input color_t tgt, input color_t prev,
                                      input int unsigned w);
    int unsigned full;
    int unsigned t;
    full = 32'(lpg_pkg::PCT_FULL);
    // Each weighted term is truncated on its own before the sum.
    t = (32'(tgt) * (full - w)) / full + (32'(prev) * w) / full;
    return (t > 255) ? 8'hFF : t[lpg_pkg::COLOR_W-1:0];
  endfunction

  function automatic color_t fade_step(input color_t tgt, input color_t prev,
                                       input int unsigned s);
    int unsigned d;
    if (tgt > prev) begin
      d = 32'(tgt) - 32'(prev);
      return lpg_pkg::COLOR_W'(32'(prev) + ((s < d) ? s : d));
    end
    if (tgt < prev) begin
      d = 32'(prev) - 32'(tgt);
      return lpg_pkg::COLOR_W'(32'(prev) - ((s < d) ? s : d));
    end
    return prev;
  endfunction

  function automatic pixel_t predict_shown(input pixel_t px);
    int unsigned slot;
    int unsigned w;
    pixel_t      res;
    slot = 32'(px.idx) % LEDS;
    res = px;
    case (cur_mode)
      lpg_pkg::MODE_GLOW: begin
        w = 32'((cur_amount > lpg_pkg::GLOW_MAX) ? lpg_pkg::GLOW_MAX : cur_amount);
        shown_hist[slot].red   = glow_mix(px.color.red, shown_hist[slot].red, w);
        shown_hist[slot].green = glow_mix(px.color.green, shown_hist[slot].green, w);
        shown_hist[slot].blue  = glow_mix(px.color.blue, shown_hist[slot].blue, w);
        res.color = shown_hist[slot];
      end
      lpg_pkg::MODE_FADE: begin
        w = 32'((cur_amount > lpg_pkg::FADE_MAX) ? lpg_pkg::FADE_MAX : cur_amount);
        shown_hist[slot].red   = fade_step(px.color.red, shown_hist[slot].red, w);
        shown_hist[slot].green = fade_step(px.color.green, shown_hist[slot].green, w);
        shown_hist[slot].blue  = fade_step(px.color.blue, shown_hist[slot].blue, w);
        res.color = shown_hist[slot];
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic send_pixel(input logic [lpg_pkg::IDX_W-1:0] idx, input color_t r,
                            input color_t g, input color_t b, input logic last);
    int     gap;
    pixel_t px;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_if.valid     = 1'b0;
      in_if.in_red    = lpg_pkg::COLOR_W'($urandom);
      in_if.led_index = lpg_pkg::IDX_W'($urandom);
    end
    @(negedge clk);
    in_if.valid      = 1'b1;
    in_if.led_index  = idx;
    in_if.in_red     = r;
    in_if.in_green   = g;
    in_if.in_blue    = b;
    in_if.frame_last = last;
    do @(posedge clk); while (!in_if.ready);
    px.idx   = idx;
    px.color = '{red: r, green: g, blue: b};
    px.last  = last;
    due_pixels.push_back(predict_shown(px));
  endtask

  // Lowers valid, then waits until every word has come out and the pipeline is empty.
  task automatic drain();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (due_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input lpg_pkg::cfg_idx_t reg_sel, input amount_t value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = reg_sel;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    cfg_wdata = lpg_pkg::CFG_DATA_W'($urandom);
    if (reg_sel == lpg_pkg::CFG_MODE) cur_mode = value[1:0];
    else cur_amount = value;
  endtask

  task automatic set_effect(input logic [1:0] mode, input amount_t amount);
    drain();
    write_reg(lpg_pkg::CFG_MODE, lpg_pkg::CFG_DATA_W'(mode));
    write_reg(lpg_pkg::CFG_AMOUNT, amount);
  endtask

  task automatic report(input string field, input int want, input int got);
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin : check_words
    pixel_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (due_pixels.size() == 0) begin
        $display("%0t ns: unexpected word, expected none, actual idx %0d rgb %02h%02h%02h",
                 $time, out_if.out_index, out_if.out_red, out_if.out_green, out_if.out_blue);
        fail_count++;
      end else begin
        want = due_pixels.pop_front();
        if (out_if.out_index !== want.idx)
          report("out_index", int'(want.idx), int'(out_if.out_index));
        if (out_if.out_red !== want.color.red)
          report("out_red", int'(want.color.red), int'(out_if.out_red));
        if (out_if.out_green !== want.color.green)
          report("out_green", int'(want.color.green), int'(out_if.out_green));
        if (out_if.out_blue !== want.color.blue)
          report("out_blue", int'(want.color.blue), int'(out_if.out_blue));
        if (out_if.out_last !== want.last)
          report("out_last", int'(want.last), int'(out_if.out_last));
      end
    end
  end

  // Reset settings: passthrough, with the history left black; also the unused mode.
  task automatic test_passthrough();
    send_pixel(3'd0, 8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(3'd7, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_pixel(3'd3, 8'hA5, 8'h5A, 8'hC3, 1'b0);
    set_effect(2'd3, 7'd50);
    send_pixel(3'd5, 8'h12, 8'hFE, 8'h01, 1'b1);
    send_pixel(3'd2, 8'h80, 8'h7F, 8'h40, 1'b0);
  endtask

  task automatic test_glow();
    set_effect(lpg_pkg::MODE_GLOW, 7'd0);
    send_pixel(3'd1, 8'hFF, 8'h00, 8'h80, 1'b0);
    send_pixel(3'd6, 8'h55, 8'hAA, 8'hFF, 1'b1);
    // An amount above the top of the range acts as the heaviest smoothing.
    set_effect(lpg_pkg::MODE_GLOW, 7'd127);
    send_pixel(3'd1, 8'h00, 8'hFF, 8'h00, 1'b0);
    send_pixel(3'd1, 8'h00, 8'hFF, 8'h00, 1'b0);
    send_pixel(3'd4, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    set_effect(lpg_pkg::MODE_GLOW, 7'd50);
    send_pixel(3'd6, 8'h00, 8'hFF, 8'h01, 1'b0);
    send_pixel(3'd6, 8'hFF, 8'h00, 8'hFF, 1'b1);
  endtask

  task automatic test_fade();
    // Step above the cap is limited, in both directions and for equal values.
    set_effect(lpg_pkg::MODE_FADE, 7'd127);
    send_pixel(3'd0, 8'hFF, 8'h05, 8'h00, 1'b0);
    send_pixel(3'd6, 8'h00, 8'hFF, 8'h80, 1'b0);
    send_pixel(3'd4, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    set_effect(lpg_pkg::MODE_FADE, 7'd0);
    send_pixel(3'd0, 8'h00, 8'hFF, 8'h80, 1'b0);
    send_pixel(3'd7, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    set_effect(lpg_pkg::MODE_FADE, 7'd3);
    send_pixel(3'd0, 8'h0B, 8'h06, 8'h01, 1'b0);
    send_pixel(3'd6, 8'h7F, 8'h7F, 8'h7F, 1'b1);
  endtask

  function automatic color_t pick_color();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 12) return 8'h00;
    if (p < 24) return 8'hFF;
    return lpg_pkg::COLOR_W'($urandom);
  endfunction

  function automatic amount_t pick_amount();
    case ($urandom_range(0, 9))
      0: return 7'd0;
      1: return 7'd1;
      2: return lpg_pkg::FADE_MAX;
      3: return lpg_pkg::FADE_MAX + 7'd1;
      4: return lpg_pkg::GLOW_MAX;
      5: return lpg_pkg::PCT_FULL;
      6: return 7'd127;
      7: return lpg_pkg::CFG_DATA_W'($urandom_range(2, 9));
      default: return lpg_pkg::CFG_DATA_W'($urandom_range(0, 127));
    endcase
  endfunction

  // Frames of pixels under changing settings; most frames walk the strip in order.
  task automatic test_random_frames();
    int          sent;
    int          phase_end;
    int          len;
    logic [1:0]  mode;
    bit          in_order;
    logic        last;
    sent = 0;
    while (sent < 480) begin
      mode = ($urandom_range(0, 9) < 8) ? 2'($urandom_range(1, 2))
                                        : 2'($urandom_range(0, 3));
      set_effect(mode, pick_amount());
      steady = ($urandom_range(0, 4) == 0);
      phase_end = sent + $urandom_range(25, 55);
      while (sent < phase_end) begin
        len = $urandom_range(1, LEDS);
        in_order = ($urandom_range(0, 9) < 7);
        for (int k = 0; k < len; k++) begin
          last = ($urandom_range(0, 9) == 0) ? 1'($urandom_range(0, 1)) : (k == len - 1);
          send_pixel(in_order ? lpg_pkg::IDX_W'(k)
                              : lpg_pkg::IDX_W'($urandom_range(0, LEDS - 1)),
                     pick_color(), pick_color(), pick_color(), last);
          sent++;
        end
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    test_passthrough();
    test_glow();
    test_fade();
    test_random_frames();
    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && due_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: led_pixel_glow_fade_filter.f
sv/lpg_pkg.sv
sv/lpg_pix_if.sv
sv/lpg_cfg.sv
sv/lpg_chan.sv
sv/led_pixel_glow_fade_filter.sv
bench/tb_top.sv
